// File: sv/tcbd_pkg.sv
// Types and constants shared by the top-candidate bypass decider.
package tcbd_pkg;

   localparam int TOKEN_ID_BITS = 20;
   localparam int KEEP          = 5;
   localparam int SEEN_BITS     = 3;
   localparam int PROB_BITS     = 17;
   localparam int LOGIT_BITS    = 32;
   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 31;
   localparam int EPS_BITS      = 17;
   localparam int THR_BITS      = 31;
   localparam int FACTOR_BITS   = 16;
   localparam int TAIL_BITS     = PROB_BITS + 2;
   localparam int PROD_BITS     = FACTOR_BITS + TAIL_BITS;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_PROB_TIE_EPSILON       = 2'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_LOGIT_MARGIN_THRESHOLD = 2'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_TAIL_DOMINANCE_FACTOR  = 2'd2;

   localparam logic [EPS_BITS-1:0]    EPS_RESET    = 17'd1311;
   localparam logic [THR_BITS-1:0]    THR_RESET    = 31'd144179;
   localparam logic [FACTOR_BITS-1:0] FACTOR_RESET = 16'd333;

   localparam logic [2:0] REASON_NONE   = 3'd0;
   localparam logic [2:0] REASON_SINGLE = 3'd1;
   localparam logic [2:0] REASON_LOGIT  = 3'd2;
   localparam logic [2:0] REASON_TIE    = 3'd3;
   localparam logic [2:0] REASON_TAIL   = 3'd4;

   localparam logic signed [31:0] MARGIN_ONE = 32'sd65536;

   typedef struct packed {
      logic [TOKEN_ID_BITS-1:0]     token_id;
      logic signed [LOGIT_BITS-1:0] logit_value;
      logic [PROB_BITS-1:0]         probability;
      logic                         last_candidate;
   } req_payload_type;

   typedef struct packed {
      logic                  bypass;
      logic [2:0]            reason_code;
      logic signed [31:0]    margin;
      logic [TOKEN_ID_BITS-1:0] top_token;
   } rsp_payload_type;

   typedef struct packed {
      logic signed [LOGIT_BITS-1:0] logit;
      logic [PROB_BITS-1:0]         prob;
      logic [TOKEN_ID_BITS-1:0]     id;
   } entry_type;

   typedef struct packed {
      logic single;
      logic full;
   } set_info_type;

   typedef struct packed {
      logic [EPS_BITS-1:0]    eps;
      logic [THR_BITS-1:0]    thr;
      logic [FACTOR_BITS-1:0] factor;
   } cfg_type;

endpackage

// File: sv/tcbd_topfive.sv
// Sorted store of the five highest-logit candidates with registered insertion.
module tcbd_topfive import tcbd_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   ins_en,
   input  entry_type              cand,
   input  logic                   cand_last,
   output entry_type [KEEP-1:0]   best,
   output set_info_type           info
);

   entry_type [KEEP-1:0] best_ff, best_in;
   logic [SEEN_BITS-1:0] seen_ff, seen_in;
   set_info_type         info_ff, info_in;
   logic [KEEP-1:0]      gt;

   always_comb begin
      for (int i = 0; i < KEEP; i++) begin
         gt[i] = (SEEN_BITS'(i) < seen_ff) && (best_ff[i].logit >= cand.logit);
      end
      best_in[0] = gt[0] ? best_ff[0] : cand;
      for (int i = 1; i < KEEP; i++) begin
         if (gt[i]) begin
            best_in[i] = best_ff[i];
         end else if (gt[i-1]) begin
            best_in[i] = cand;
         end else begin
            best_in[i] = best_ff[i-1];
         end
      end
   end

   always_comb begin
      seen_in = seen_ff;
      info_in = info_ff;
      if (ins_en) begin
         info_in.single = (seen_ff == '0);
         info_in.full   = (seen_ff >= SEEN_BITS'(KEEP - 1));
         if (cand_last) begin
            seen_in = '0;
         end else if (seen_ff < SEEN_BITS'(KEEP)) begin
            seen_in = seen_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
      end else begin
         seen_ff <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ins_en) begin
         best_ff <= best_in;
      end
      if (ins_en && cand_last) begin
         info_ff <= info_in;
      end
   end

   assign best = best_ff;
   assign info = info_ff;

endmodule

// File: sv/tcbd_decide.sv
// Single-pass decision logic from the top five into the result register.
module tcbd_decide import tcbd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  entry_type [KEEP-1:0] best,
   input  set_info_type         info,
   input  cfg_type              cfg,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_payload_type      rsp_data
);

   logic                         take;
   logic signed [LOGIT_BITS:0]   dl;
   logic signed [PROB_BITS:0]    dp;
   logic signed [PROB_BITS:0]    adp;
   logic [TAIL_BITS-1:0]         tail;
   logic [PROD_BITS-1:0]         prod;
   logic signed [TAIL_BITS:0]    tm_raw;
   logic signed [31:0]           dl_sat;
   logic signed [31:0]           dp_ext;
   logic signed [31:0]           tm_ext;
   logic                         logit_hit;
   logic                         tie_hit;
   logic                         tail_hit;

   logic                         rsp_valid_ff, rsp_valid_in;
   rsp_payload_type              rsp_data_ff, rsp_data_in;

   assign take     = !rsp_valid_ff || rsp_ready;
   assign in_ready = take;

   // differences, tail sum, product and compares
   always_comb begin
      dl        = {best[0].logit[LOGIT_BITS-1], best[0].logit}
                - {best[1].logit[LOGIT_BITS-1], best[1].logit};
      dp        = $signed({1'b0, best[0].prob}) - $signed({1'b0, best[1].prob});
      adp       = dp[PROB_BITS] ? -dp : dp;
      tail      = TAIL_BITS'(best[1].prob) + TAIL_BITS'(best[2].prob)
                + TAIL_BITS'(best[3].prob) + TAIL_BITS'(best[4].prob);
      prod      = PROD_BITS'(cfg.factor) * PROD_BITS'(tail);
      tm_raw    = $signed({3'b000, best[0].prob}) - $signed({1'b0, tail});
      logit_hit = dl > $signed({2'b00, cfg.thr});
      tie_hit   = (best[0].prob != '0) && (adp < $signed({1'b0, cfg.eps}));
      tail_hit  = info.full && (best[0].prob != '0)
                && (PROD_BITS'({best[0].prob, 8'h00}) > prod);
      if (dl[LOGIT_BITS] != dl[LOGIT_BITS-1]) begin
         dl_sat = dl[LOGIT_BITS] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         dl_sat = dl[31:0];
      end
      dp_ext = 32'(dp);
      tm_ext = 32'(tm_raw);
   end

   // reason selection into the result register
   always_comb begin
      rsp_valid_in = take ? in_valid : rsp_valid_ff;
      rsp_data_in.top_token = best[0].id;
      priority if (info.single) begin
         rsp_data_in.bypass      = 1'b1;
         rsp_data_in.reason_code = REASON_SINGLE;
         rsp_data_in.margin      = MARGIN_ONE;
      end else if (logit_hit) begin
         rsp_data_in.bypass      = 1'b1;
         rsp_data_in.reason_code = REASON_LOGIT;
         rsp_data_in.margin      = dl_sat;
      end else if (tie_hit) begin
         rsp_data_in.bypass      = 1'b1;
         rsp_data_in.reason_code = REASON_TIE;
         rsp_data_in.margin      = dp_ext;
      end else if (tail_hit) begin
         rsp_data_in.bypass      = 1'b1;
         rsp_data_in.reason_code = REASON_TAIL;
         rsp_data_in.margin      = tm_ext;
      end else begin
         rsp_data_in.bypass      = 1'b0;
         rsp_data_in.reason_code = REASON_NONE;
         rsp_data_in.margin      = dp_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && in_valid) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: sv/top_candidate_bypass_decider.sv
// Top level of the top-candidate bypass decider.
// Candidates are taken at one per cycle while req_ready is high; each is
// compared against the five stored best logits in parallel and inserted by
// a compare-and-shift, which sets the rate. Accepting the transaction
// marked last_candidate completes the top five and sets a pending flag;
// rsp_valid rises as the result register takes the decision, which is plain
// combinational logic between the top-five store and the result register
// (differences, tail sum, one product, compares and reason selection).
// A new set may start in the cycle after a last candidate; input is held off
// only while a finished set waits on a result register that is full and not
// being taken, since any further candidate would alter the stored top five.
// Configuration: csr_addr 0 tie epsilon, 1 logit margin threshold,
// 2 tail dominance factor; other addresses are ignored.
module top_candidate_bypass_decider import tcbd_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_payload_type          req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_payload_type          rsp_data,
   input  logic                     csr_we,
   input  logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   cfg_type              cfg_ff, cfg_in;
   logic                 pend_ff, pend_in;
   logic                 req_fire;
   logic                 dec_ready;
   entry_type            cand;
   entry_type [KEEP-1:0] best;
   set_info_type         info;

   assign req_ready = !pend_ff || dec_ready;
   assign req_fire  = req_valid && req_ready;

   assign cand.logit = req_data.logit_value;
   assign cand.prob  = req_data.probability;
   assign cand.id    = req_data.token_id;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_PROB_TIE_EPSILON:       cfg_in.eps    = csr_wdata[EPS_BITS-1:0];
            CSR_LOGIT_MARGIN_THRESHOLD: cfg_in.thr    = csr_wdata[THR_BITS-1:0];
            CSR_TAIL_DOMINANCE_FACTOR:  cfg_in.factor = csr_wdata[FACTOR_BITS-1:0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      if (req_fire && req_data.last_candidate) begin
         pend_in = 1'b1;
      end else if (dec_ready) begin
         pend_in = 1'b0;
      end else begin
         pend_in = pend_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.eps    <= EPS_RESET;
         cfg_ff.thr    <= THR_RESET;
         cfg_ff.factor <= FACTOR_RESET;
         pend_ff       <= 1'b0;
      end else begin
         cfg_ff  <= cfg_in;
         pend_ff <= pend_in;
      end
   end

   tcbd_topfive u_topfive (
      .clock     (clock),
      .reset     (reset),
      .ins_en    (req_fire),
      .cand      (cand),
      .cand_last (req_data.last_candidate),
      .best      (best),
      .info      (info)
   );

   tcbd_decide u_decide (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pend_ff),
      .in_ready  (dec_ready),
      .best      (best),
      .info      (info),
      .cfg       (cfg_ff),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
